### rtl/ecr_pkg.sv
// ----------------------------------------------------------------------------
// Echo ranger package
// Shared types and constants for the ultrasonic echo ranger: phase codes,
// register indexes, configuration and result records, distance scaling.
// ----------------------------------------------------------------------------
package ecr_pkg;

   // Measurement sequence phases, one-hot.
   typedef enum logic [4:0] {
      PH_TRIG_LOW  = 5'b00001,
      PH_TRIG_HIGH = 5'b00010,
      PH_WAIT_RISE = 5'b00100,
      PH_MEASURE   = 5'b01000,
      PH_PAUSE     = 5'b10000
   } phase_type;

   // Configuration register indexes.
   localparam logic [1:0] REG_CYCLES_PER_US = 2'd0;
   localparam logic [1:0] REG_TIMEOUT_US    = 2'd1;
   localparam logic [1:0] REG_THRESHOLD     = 2'd2;
   localparam logic [1:0] REG_PAUSE_US      = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Trigger timing in microseconds.
   localparam int TRIG_LOW_US  = 2;
   localparam int TRIG_HIGH_US = 10;

   localparam int WIDTH_W = 16;
   localparam int DIST_W  = 15;

   // distance = width*16/58 = (width*8)/29, done as a multiply by
   // ceil(2^24/29); exact for every 16-bit width.
   localparam int          DIST_SHIFT = 24;
   localparam int          RECIP_W    = 20;
   localparam logic [19:0] DIST_RECIP = 20'd578525;

   localparam logic [7:0]  RST_CYCLES_PER_US = 8'd84;
   localparam logic [15:0] RST_TIMEOUT_US    = 16'd30000;
   localparam logic [15:0] RST_THRESHOLD     = 16'd320;
   localparam logic [15:0] RST_PAUSE_US      = 16'd60000;

   typedef struct packed {
      logic [7:0]  cycles_per_us;
      logic [15:0] timeout_us;
      logic [15:0] threshold_sixteenths;
      logic [15:0] pause_us;
   } cfg_type;

   typedef struct packed {
      logic [DIST_W-1:0]  distance_sixteenths;
      logic [WIDTH_W-1:0] echo_width_us;
      logic               timed_out;
      logic               measure_done;
      logic               led_on;
      logic               trig_level;
   } result_type;

endpackage

### rtl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Drives the trigger, times the echo pulse and reports distance and a
// near indication, one result for every sampled clock tick.
//
//  Channel  Direction  Payload
//  req_     in         echo pin sample, one per ranger tick
//  rsp_     out        trigger, LED, done/timeout flags, echo width, distance
//  csr_     in         register index and write data, always ready
//
// One item is accepted every clock cycle when the result side keeps up.
// An accepted item waits in the input register, then moves to the result
// register when that register is free.
// Reset clears the sequencer to trigger low and restores register defaults.
// A stalled result holds the input register; req_tready falls only when
// both registers are full and rsp_tready is low.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger
   import ecr_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [0] echo_level
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata,   // [0] trig_level, [1] led_on,
                                               // [2] measure_done, [3] timed_out,
                                               // [19:4] echo_width_us,
                                               // [34:20] distance_sixteenths
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   logic       echo_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       step;
   logic       out_free;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !rsp_tready);

   ecr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ecr_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step       (step),
      .echo_level (echo_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         echo_ff <= req_tdata[0];
      end
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, out_ff};

endmodule

### rtl/ecr_csr.sv
// ----------------------------------------------------------------------------
// Echo ranger configuration registers
// Holds the four writable settings and presents them as one record.
// ----------------------------------------------------------------------------
module ecr_csr
   import ecr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_CYCLES_PER_US: cfg_in.cycles_per_us        = csr_data[7:0];
            REG_TIMEOUT_US:    cfg_in.timeout_us           = csr_data;
            REG_THRESHOLD:     cfg_in.threshold_sixteenths = csr_data;
            REG_PAUSE_US:      cfg_in.pause_us             = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cycles_per_us        <= RST_CYCLES_PER_US;
         cfg_ff.timeout_us           <= RST_TIMEOUT_US;
         cfg_ff.threshold_sixteenths <= RST_THRESHOLD;
         cfg_ff.pause_us             <= RST_PAUSE_US;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/ecr_core.sv
// ----------------------------------------------------------------------------
// Echo ranger sequencer
// Microsecond prescaler, phase sequencer, echo timer and distance scaling.
// Advances by one clock tick of the ranger for each step strobe.
// ----------------------------------------------------------------------------
module ecr_core
   import ecr_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  logic       echo_level,
   output result_type result
);

   localparam int CmpWidth = (COUNT_WIDTH > WIDTH_W) ? COUNT_WIDTH : WIDTH_W;
   localparam int ProdWidth = WIDTH_W + 3 + RECIP_W;
   localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

   phase_type              phase_ff, phase_in;
   logic [7:0]             prescale_ff, prescale_in;
   logic [COUNT_WIDTH-1:0] micro_ff, micro_in;
   logic                   led_ff, led_in;

   logic [7:0]             reload;
   logic [8:0]             prescale_inc;
   logic                   tick;
   logic                   at_max;
   logic [COUNT_WIDTH-1:0] count_next;
   logic                   wait_expired;
   logic [WIDTH_W-1:0]     width;
   logic [ProdWidth-1:0]   product;
   logic [DIST_W-1:0]      distance;
   logic                   near;

   // Zero cycles_per_us counts as one, so every clock is a microsecond.
   assign reload       = (cfg.cycles_per_us == 8'd0) ? 8'd1 : cfg.cycles_per_us;
   assign prescale_inc = {1'b0, prescale_ff} + 9'd1;
   assign tick         = (prescale_inc >= {1'b0, reload});

   assign at_max       = (micro_ff == CountMax);
   assign count_next   = at_max ? CountMax : micro_ff + COUNT_WIDTH'(1);
   assign wait_expired = (CmpWidth'(micro_ff) >= CmpWidth'(cfg.timeout_us)) || at_max;

   assign width    = WIDTH_W'(micro_ff);
   assign product  = ProdWidth'({width, 3'b000}) * ProdWidth'(DIST_RECIP);
   assign distance = product[DIST_SHIFT +: DIST_W];
   assign near     = (distance != '0) && ({1'b0, distance} <= cfg.threshold_sixteenths);

   always_comb begin
      phase_in    = phase_ff;
      prescale_in = tick ? 8'd0 : prescale_inc[7:0];
      micro_in    = micro_ff;
      led_in      = led_ff;
      result      = '0;
      result.trig_level = (phase_ff == PH_TRIG_HIGH);

      unique case (phase_ff)
         PH_TRIG_HIGH: begin
            if (tick) begin
               if (CmpWidth'(count_next) >= CmpWidth'(TRIG_HIGH_US)) begin
                  phase_in = PH_WAIT_RISE;
                  micro_in = '0;
               end else begin
                  micro_in = count_next;
               end
            end
         end
         PH_WAIT_RISE: begin
            if (echo_level) begin
               phase_in = PH_MEASURE;
               micro_in = '0;
            end else if (tick) begin
               if (wait_expired) begin
                  result.measure_done = 1'b1;
                  result.timed_out    = 1'b1;
                  led_in   = 1'b0;
                  phase_in = PH_PAUSE;
                  micro_in = '0;
               end else begin
                  micro_in = count_next;
               end
            end
         end
         PH_MEASURE: begin
            // The echo level wins over a timeout on the same tick.
            if (!echo_level) begin
               result.measure_done        = 1'b1;
               result.echo_width_us       = width;
               result.distance_sixteenths = distance;
               led_in   = near;
               phase_in = PH_PAUSE;
               micro_in = '0;
            end else if (tick) begin
               if (wait_expired) begin
                  result.measure_done = 1'b1;
                  result.timed_out    = 1'b1;
                  led_in   = 1'b0;
                  phase_in = PH_PAUSE;
                  micro_in = '0;
               end else begin
                  micro_in = count_next;
               end
            end
         end
         PH_PAUSE: begin
            if (tick) begin
               if ((CmpWidth'(count_next) >= CmpWidth'(cfg.pause_us)) ||
                   (count_next == CountMax)) begin
                  phase_in = PH_TRIG_LOW;
                  micro_in = '0;
               end else begin
                  micro_in = count_next;
               end
            end
         end
         default: begin
            // Trigger low; any stray code restarts here with the count cleared, or set to one on a tick.
            phase_in = PH_TRIG_LOW;
            if (phase_ff != PH_TRIG_LOW) begin
               micro_in = '0;
               if (tick) begin
                  micro_in = COUNT_WIDTH'(1);
               end
            end else if (tick) begin
               if (CmpWidth'(count_next) >= CmpWidth'(TRIG_LOW_US)) begin
                  phase_in = PH_TRIG_HIGH;
                  micro_in = '0;
               end else begin
                  micro_in = count_next;
               end
            end
         end
      endcase

      result.led_on = led_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TRIG_LOW;
         prescale_ff <= 8'd0;
         micro_ff    <= '0;
         led_ff      <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         prescale_ff <= prescale_in;
         micro_ff    <= micro_in;
         led_ff      <= led_in;
      end
   end

endmodule

### verif/tb_ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger testbench
// Feeds echo pin samples, one per ranger tick, and keeps a cycle-exact
// model of the trigger/measure/pause sequencer alongside the block. Every
// result transfer is compared field by field with the model's prediction.
// Echo waveforms are shaped from the model's phase, so most runs complete
// real measurements, with timeouts, near/far decisions and noisy sequences
// mixed in. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger;
   import ecr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          COUNT_W     = 16;
   localparam int unsigned COUNT_MAX   = (1 << COUNT_W) - 1;
   localparam int          STALL_LIMIT = 400;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;    // [0] echo_level
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // [0] trig_level, [1] led_on, [2] measure_done,
                                      // [3] timed_out, [19:4] echo_width_us,
                                      // [34:20] distance_sixteenths
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   ultrasonic_echo_ranger #(.COUNT_WIDTH(COUNT_W)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Sequencer model state and its copy of the registers.
   cfg_type     rng_cfg;
   phase_type   rng_phase;
   int unsigned rng_prescale;
   int unsigned rng_micro;
   logic        rng_led;

   result_type  due_results_q[$];

   // Echo shaping: delay before the rise and length of the high pulse, in ticks.
   phase_type   shaped_phase = PH_TRIG_LOW;
   int unsigned rise_delay;
   int unsigned high_ticks;

   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;

   int mismatch_count;
   int samples_sent;
   int results_checked;
   int ranges_done;
   int timeouts_seen;
   int near_seen;
   int stall_cycles;

   task automatic reset_ranger_model();
      rng_cfg.cycles_per_us        = RST_CYCLES_PER_US;
      rng_cfg.timeout_us           = RST_TIMEOUT_US;
      rng_cfg.threshold_sixteenths = RST_THRESHOLD;
      rng_cfg.pause_us             = RST_PAUSE_US;
      rng_phase    = PH_TRIG_LOW;
      rng_prescale = 0;
      rng_micro    = 0;
      rng_led      = 1'b0;
   endtask

   // Advances the model by one tick and queues the result it produces.
   task automatic advance_ranger(input logic echo);
      result_type  exp_r;
      int unsigned reload;
      int unsigned nxt;
      int unsigned width;
      int unsigned distance;
      logic        tick;
      exp_r  = '0;
      reload = (rng_cfg.cycles_per_us == 0) ? 1 : rng_cfg.cycles_per_us;
      exp_r.trig_level = (rng_phase == PH_TRIG_HIGH);
      tick = (rng_prescale + 1 >= reload);
      rng_prescale = tick ? 0 : ((rng_prescale + 1) & 8'hFF);
      nxt = (rng_micro >= COUNT_MAX) ? COUNT_MAX : rng_micro + 1;
      case (rng_phase)
         PH_TRIG_HIGH: begin
            if (tick) begin
               if (nxt >= TRIG_HIGH_US) begin
                  rng_phase = PH_WAIT_RISE;
                  rng_micro = 0;
               end else begin
                  rng_micro = nxt;
               end
            end
         end
         PH_WAIT_RISE, PH_MEASURE: begin
            // The echo level wins over a timeout on the same tick.
            if (rng_phase == PH_WAIT_RISE && echo) begin
               rng_phase = PH_MEASURE;
               rng_micro = 0;
            end else if (rng_phase == PH_MEASURE && !echo) begin
               width    = rng_micro & 16'hFFFF;
               distance = (width * 16) / 58;
               exp_r.measure_done        = 1'b1;
               exp_r.echo_width_us       = width[15:0];
               exp_r.distance_sixteenths = distance[14:0];
               rng_led   = (distance != 0) && (distance <= rng_cfg.threshold_sixteenths);
               rng_phase = PH_PAUSE;
               rng_micro = 0;
            end else if (tick) begin
               if (rng_micro >= rng_cfg.timeout_us || rng_micro >= COUNT_MAX) begin
                  exp_r.measure_done = 1'b1;
                  exp_r.timed_out    = 1'b1;
                  rng_led   = 1'b0;
                  rng_phase = PH_PAUSE;
                  rng_micro = 0;
               end else begin
                  rng_micro = nxt;
               end
            end
         end
         PH_PAUSE: begin
            if (tick) begin
               if (nxt >= rng_cfg.pause_us || nxt >= COUNT_MAX) begin
                  rng_phase = PH_TRIG_LOW;
                  rng_micro = 0;
               end else begin
                  rng_micro = nxt;
               end
            end
         end
         default: begin
            if (tick) begin
               if (nxt >= TRIG_LOW_US) begin
                  rng_phase = PH_TRIG_HIGH;
                  rng_micro = 0;
               end else begin
                  rng_micro = nxt;
               end
            end
         end
      endcase
      exp_r.led_on = rng_led;
      if (exp_r.measure_done) begin
         ranges_done++;
         if (exp_r.timed_out) timeouts_seen++;
         else if (rng_led) near_seen++;
      end
      due_results_q.push_back(exp_r);
   endtask

   // Called at a rising edge; returns at the edge where the transfer happened.
   task automatic send_echo(input logic echo);
      int gap;
      gap = req_steady ? 0 : $urandom_range(12, 0);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, echo};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      advance_ranger(echo);
      samples_sent++;
   endtask

   // Echo follows the model's phase: a rise after a drawn delay once the
   // sequencer waits for it, held for a drawn length, with optional noise.
   task automatic drive_ticks(input int unsigned count, input int unsigned dly_lo,
                              input int unsigned dly_hi, input int unsigned len_lo,
                              input int unsigned len_hi, input int unsigned noise_pct);
      logic echo;
      repeat (count) begin
         if (rng_phase == PH_WAIT_RISE && shaped_phase != PH_WAIT_RISE) begin
            rise_delay = $urandom_range(dly_hi, dly_lo);
            high_ticks = $urandom_range(len_hi, len_lo);
         end
         shaped_phase = rng_phase;
         case (rng_phase)
            PH_WAIT_RISE: begin
               echo = (rise_delay == 0);
               if (rise_delay > 0) rise_delay--;
            end
            PH_MEASURE: begin
               echo = (high_ticks > 0);
               if (high_ticks > 0) high_ticks--;
            end
            default: echo = 1'b0;
         endcase
         if ($urandom_range(99, 0) < noise_pct) echo = ~echo;
         send_echo(echo);
      end
   endtask

   // Stops the sender and waits until every predicted result has arrived.
   task automatic drain_ranger();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (due_results_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] cpu, input logic [15:0] tmo,
                             input logic [15:0] thr, input logic [15:0] pau);
      logic [CSR_INDEX_W-1:0] reg_idx [4] = '{REG_CYCLES_PER_US, REG_TIMEOUT_US,
                                              REG_THRESHOLD, REG_PAUSE_US};
      logic [15:0]            value   [4];
      value[0] = {8'd0, cpu};
      value[1] = tmo;
      value[2] = thr;
      value[3] = pau;
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_idx[i];
         csr_data  <= value[i];
         do @(negedge clock); while (!csr_ready);
         @(posedge clock);
         case (reg_idx[i])
            REG_CYCLES_PER_US: rng_cfg.cycles_per_us        = value[i][7:0];
            REG_TIMEOUT_US:    rng_cfg.timeout_us           = value[i];
            REG_THRESHOLD:     rng_cfg.threshold_sixteenths = value[i];
            default:           rng_cfg.pause_us             = value[i];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Result side: random stalls, comparison at the falling edge before the transfer.
   initial begin : result_checker
      result_type got;
      result_type want;
      int         stall;
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_steady ? 0 : $urandom_range(12, 0);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         got = rsp_tdata[34:0];
         check_field("tdata padding", 0, rsp_tdata[39:35]);
         if (due_results_q.size() == 0) begin
            $error("result transfer with no prediction pending");
            mismatch_count++;
         end else begin
            want = due_results_q.pop_front();
            check_field("trig_level", want.trig_level, got.trig_level);
            check_field("led_on", want.led_on, got.led_on);
            check_field("measure_done", want.measure_done, got.measure_done);
            check_field("timed_out", want.timed_out, got.timed_out);
            check_field("echo_width_us", want.echo_width_us, got.echo_width_us);
            check_field("distance_sixteenths", want.distance_sixteenths,
                        got.distance_sixteenths);
         end
         results_checked++;
         @(posedge clock);
      end
   end

   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results still due",
                     stall_cycles, due_results_q.size());
            $display("ultrasonic_echo_ranger verification failed");
            $finish;
         end
      end
   end

   // Register defaults: prescaler slower than the run, echo toggling freely.
   task automatic test_reset_defaults();
      drive_ticks(8, 0, 0, 0, 0, 50);
   endtask

   // Zero prescale acts as one, zero timeout expires on the first microsecond
   // unless the echo rises on that tick, zero pause ends at once.
   task automatic test_zero_settings();
      drain_ranger();
      set_config(8'd0, 16'd0, 16'd0, 16'd0);
      drive_ticks(15, 0, 0, 0, 0, 0);
      drive_ticks(15, 4, 4, 0, 0, 0);
      drive_ticks(15, 0, 0, 5, 5, 0);
   endtask

   // Short echoes around the threshold, including a zero distance.
   task automatic test_near_threshold();
      drain_ranger();
      set_config(8'd1, 16'd40, 16'd2, 16'd0);
      drive_ticks(120, 0, 2, 2, 14, 0);
   endtask

   task automatic test_register_extremes();
      drain_ranger();
      set_config(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      drive_ticks(10, 0, 0, 0, 0, 50);
      // One long echo with the widest timeout and threshold.
      drain_ranger();
      set_config(8'd1, 16'hFFFF, 16'hFFFF, 16'd0);
      drive_ticks(320, 0, 0, 300, 300, 0);
   endtask

   task automatic test_random_ranging();
      int unsigned cpu;
      int unsigned tmo;
      int unsigned span;
      for (int p = 0; p < 6; p++) begin
         cpu = $urandom_range(3, 1);
         tmo = $urandom_range(60, 4);
         drain_ranger();
         set_config(8'(cpu), 16'(tmo),
                    ($urandom_range(3, 0) == 0) ? 16'hFFFF : 16'($urandom_range(16, 0)),
                    16'($urandom_range(12, 0)));
         req_steady = ($urandom_range(3, 0) == 0);
         rsp_steady = ($urandom_range(3, 0) == 0);
         span = (tmo + tmo / 4 + 3) * cpu;
         if (p == 2) begin
            // Sender holds off mid-sequence until the result side has caught up.
            drive_ticks(100, 0, span, 0, span, 3);
            drain_ranger();
            drive_ticks(100, 0, span, 0, span, 3);
         end else begin
            drive_ticks(200, 0, span, 0, span, 3);
         end
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   task automatic test_broken_sequences();
      drain_ranger();
      set_config(8'd1, 16'd20, 16'd4, 16'd3);
      drive_ticks(200, 0, 25, 0, 25, 40);
   endtask

   initial begin
      reset_ranger_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_zero_settings();
      test_near_threshold();
      test_register_extremes();
      test_random_ranging();
      test_broken_sequences();
      drain_ranger();
      $display("Sent %0d echo samples, checked %0d results.", samples_sent, results_checked);
      $display("Sequencer finished %0d ranges: %0d timed out, %0d lit the LED.",
               ranges_done, timeouts_seen, near_seen);
      if (mismatch_count == 0 && due_results_q.size() == 0) begin
         $display("ultrasonic_echo_ranger verification clean");
      end else begin
         $display("ultrasonic_echo_ranger verification failed");
      end
      $finish;
   end

endmodule
